@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rnm assertion failed");

// next-cycle implication
`define RNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rnm assertion failed");

`endif

@@ rtl/core/rnm_pkg.sv @@
// Types and constants of the NFA line matcher.
// No dependencies.
package rnm_pkg;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_BUILD  = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_EOL    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_CLOSE,
		ST_DONE
	} state_t;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BAR    = 8'h7C;

	localparam int NUM_LINKS = 5;

	typedef struct packed {
		logic       load_char;
		logic       rotate;
		logic       clear_row;
		logic       add_links;
		logic       close_step;
		logic [7:0] char_in;
	} cell_ctrl_t;

endpackage

@@ rtl/core/rnm_if.sv @@
// Request and response channel interfaces of the NFA line matcher.
// No dependencies.
interface rnm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;
	modport source(output valid, output action, output symbol, input ready);
	modport sink(input valid, input action, input symbol, output ready);
endinterface

interface rnm_rsp_if;
	logic valid;
	logic ready;
	logic kind;
	logic matched;
	logic pattern_error;
	modport source(output valid, output kind, output matched, output pattern_error, input ready);
	modport sink(input valid, input kind, input matched, input pattern_error, output ready);
endinterface

@@ rtl/core/regex_nfa_line_matcher_core.sv @@
// Thompson NFA line matcher: ring of state cells, build sequencer, operator stack.
// Depends on rnm_pkg, rnm_if, rnm_cell.
//
//  channel | dir | payload                         | results
//  req     | in  | action[1:0], symbol[7:0]        | build, end of line give one
//  rsp     | out | kind, matched, pattern_error    | one register, skid-free
//
// The text step is one OR over cell rows. Build is a scan that rotates the byte ring once,
// a bar check, then a Warshall pass that rotates the closure rows once around the ring.
// Reset clears control state and flags; rows and bytes are rewritten on use.
// req stalls during a build and while a response is held and not taken.
module regex_nfa_line_matcher_core #(
	parameter int MAX_PATTERN = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rnm_req_if.sink      req,
	rnm_rsp_if.source    rsp
);
	import rnm_pkg::*;

	localparam int N  = MAX_PATTERN + 1;
	localparam int SW = $clog2(N);
	localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	state_t state_q, state_d;

	logic [SW-1:0] len_q, cnt_q;
	logic          ready_q, fault_q;
	logic [N-1:0]  active_q;

	logic [PW-1:0] stk_idx_q [MAX_PATTERN];
	logic          stk_bar_q [MAX_PATTERN];
	logic          stk_vld_q [MAX_PATTERN];
	logic [PW-1:0] stk_idx_d [MAX_PATTERN];
	logic          stk_bar_d [MAX_PATTERN];
	logic          stk_vld_d [MAX_PATTERN];

	logic out_valid_q, out_kind_q, out_matched_q, out_err_q;

	cell_ctrl_t    ctrl;
	logic [7:0]    cell_char [N];
	logic [N-1:0]  cell_row  [N];
	logic [N-1:0]  cell_upd  [N];
	logic          cell_hit  [N];
	logic [SW-1:0] link_from [NUM_LINKS];
	logic [SW-1:0] link_to   [NUM_LINKS];
	logic [NUM_LINKS-1:0] link_en;

	logic          acc;
	logic          scan_on, push, pop1, pop2, scan_fault, star_next, self_link;
	logic [7:0]    c_cur, c_nxt;
	logic [SW-1:0] left, top_idx, i_plus1;
	logic          bar_left;
	logic [N-1:0]  step_set;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			rnm_cell #(.N(N), .SW(SW), .P(g)) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.wr_idx    (ready_q ? '0 : len_q),
				.symbol    (req.symbol),
				.char_next (cell_char[(g + 1) % N]),
				.row_next  (cell_upd[(g + 1) % N]),
				.bcast     (cell_row[0]),
				.k         (cnt_q),
				.link_from (link_from),
				.link_to   (link_to),
				.link_en   (link_en),
				.char_out  (cell_char[g]),
				.row_out   (cell_row[g]),
				.upd_out   (cell_upd[g]),
				.hit       (cell_hit[g])
			);
		end
	endgenerate

	// build scan: byte i sits in cell 0, byte i+1 in cell 1
	always_comb begin
		c_cur      = cell_char[0];
		c_nxt      = cell_char[1];
		scan_on    = (state_q == ST_SCAN) && (cnt_q < len_q);
		i_plus1    = cnt_q + SW'(1);
		top_idx    = SW'(stk_idx_q[0]);
		push       = scan_on && (c_cur == CH_LPAREN || c_cur == CH_BAR)
		             && !stk_vld_q[MAX_PATTERN-1];
		pop1       = 1'b0;
		pop2       = 1'b0;
		scan_fault = 1'b0;
		left       = cnt_q;
		if (scan_on && c_cur == CH_RPAREN) begin
			if (!stk_vld_q[0]) begin
				scan_fault = 1'b1;
			end else if (stk_bar_q[0]) begin
				if (!stk_vld_q[1]) begin
					scan_fault = 1'b1;
					pop1       = 1'b1;
				end else begin
					pop2 = 1'b1;
					left = SW'(stk_idx_q[1]);
				end
			end else begin
				pop1 = 1'b1;
				left = top_idx;
			end
		end
		star_next = scan_on && (i_plus1 < len_q) && (c_nxt == CH_STAR);
		self_link = scan_on && (c_cur == CH_LPAREN || c_cur == CH_STAR || c_cur == CH_RPAREN);
		link_from[0] = left;    link_to[0] = top_idx + SW'(1); link_en[0] = pop2;
		link_from[1] = top_idx; link_to[1] = cnt_q;            link_en[1] = pop2;
		link_from[2] = left;    link_to[2] = i_plus1;          link_en[2] = star_next;
		link_from[3] = i_plus1; link_to[3] = left;             link_en[3] = star_next;
		link_from[4] = cnt_q;   link_to[4] = i_plus1;          link_en[4] = self_link;
	end

	always_comb begin
		int s1, s2;
		s1 = 0;
		s2 = 0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			s1 = (j + 1 < MAX_PATTERN) ? j + 1 : j;
			s2 = (j + 2 < MAX_PATTERN) ? j + 2 : j;
			stk_idx_d[j] = stk_idx_q[j];
			stk_bar_d[j] = stk_bar_q[j];
			stk_vld_d[j] = stk_vld_q[j];
			if (acc && req.action == ACT_BUILD) begin
				stk_vld_d[j] = 1'b0;
			end else if (push) begin
				stk_idx_d[j] = (j == 0) ? PW'(cnt_q) : stk_idx_q[(j > 0) ? j - 1 : 0];
				stk_bar_d[j] = (j == 0) ? (c_cur == CH_BAR) : stk_bar_q[(j > 0) ? j - 1 : 0];
				stk_vld_d[j] = (j == 0) ? 1'b1 : stk_vld_q[(j > 0) ? j - 1 : 0];
			end else if (pop1) begin
				stk_idx_d[j] = stk_idx_q[s1];
				stk_bar_d[j] = stk_bar_q[s1];
				stk_vld_d[j] = (j + 1 < MAX_PATTERN) ? stk_vld_q[s1] : 1'b0;
			end else if (pop2) begin
				stk_idx_d[j] = stk_idx_q[s2];
				stk_bar_d[j] = stk_bar_q[s2];
				stk_vld_d[j] = (j + 2 < MAX_PATTERN) ? stk_vld_q[s2] : 1'b0;
			end
		end
	end

	always_comb begin
		bar_left = 1'b0;
		for (int j = 0; j < MAX_PATTERN; j++)
			bar_left = bar_left | (stk_vld_q[j] & stk_bar_q[j]);
	end

	always_comb begin
		step_set = '0;
		for (int v = 0; v < MAX_PATTERN; v++) begin
			if (active_q[v] && SW'(v) < len_q && cell_hit[v])
				step_set = step_set | cell_row[v + 1];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc && req.action == ACT_BUILD) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == SW'(N - 1)) state_d = ST_CHECK;
			ST_CHECK: state_d = ST_CLOSE;
			ST_CLOSE: if (cnt_q == SW'(N - 1)) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.char_in = req.symbol;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.load_char = acc && req.action == ACT_APPEND
				                 && (ready_q || len_q < SW'(MAX_PATTERN));
				ctrl.clear_row = acc && req.action == ACT_BUILD;
			end
			ST_SCAN: begin
				ctrl.rotate    = 1'b1;
				ctrl.add_links = 1'b1;
			end
			ST_CLOSE: ctrl.close_step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			cnt_q    <= '0;
			ready_q  <= 1'b0;
			fault_q  <= 1'b0;
			active_q <= '0;
			for (int j = 0; j < MAX_PATTERN; j++) stk_vld_q[j] <= 1'b0;
		end else begin
			state_q <= state_d;
			for (int j = 0; j < MAX_PATTERN; j++) stk_vld_q[j] <= stk_vld_d[j];
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						unique case (req.action)
							ACT_APPEND: begin
								if (ready_q) begin
									ready_q  <= 1'b0;
									fault_q  <= 1'b0;
									active_q <= '0;
									len_q    <= SW'(1);
								end else if (len_q < SW'(MAX_PATTERN)) begin
									len_q <= len_q + SW'(1);
								end else begin
									fault_q <= 1'b1;
								end
							end
							ACT_BUILD: ;
							ACT_TEXT:  if (ready_q) active_q <= step_set;
							ACT_EOL:   if (ready_q) active_q <= cell_row[0];
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					cnt_q <= (cnt_q == SW'(N - 1)) ? '0 : cnt_q + SW'(1);
					if (scan_fault) fault_q <= 1'b1;
				end
				ST_CHECK: if (bar_left) fault_q <= 1'b1;
				ST_CLOSE: cnt_q <= (cnt_q == SW'(N - 1)) ? '0 : cnt_q + SW'(1);
				ST_DONE: begin
					ready_q  <= 1'b1;
					active_q <= cell_row[0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			stk_idx_q[j] <= stk_idx_d[j];
			stk_bar_q[j] <= stk_bar_d[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE || (acc && req.action == ACT_EOL)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			out_kind_q    <= KIND_STATUS;
			out_matched_q <= 1'b0;
			out_err_q     <= fault_q;
		end else if (acc && req.action == ACT_EOL) begin
			out_kind_q    <= KIND_VERDICT;
			out_matched_q <= ready_q && !fault_q && active_q[len_q];
			out_err_q     <= fault_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.kind          = out_kind_q;
	assign rsp.matched       = out_matched_q;
	assign rsp.pattern_error = out_err_q;

endmodule

@@ rtl/core/rnm_cell.sv @@
// One NFA state cell: pattern byte and epsilon/closure row, ring-linked to its neighbor.
// Depends on rnm_pkg.
module rnm_cell #(
	parameter int N  = 33,
	parameter int SW = 6,
	parameter int P  = 0
) (
	input  logic                clk,
	input  rnm_pkg::cell_ctrl_t ctrl,
	input  logic [SW-1:0]       wr_idx,
	input  logic [7:0]          symbol,
	input  logic [7:0]          char_next,
	input  logic [N-1:0]        row_next,
	input  logic [N-1:0]        bcast,
	input  logic [SW-1:0]       k,
	input  logic [SW-1:0]       link_from [rnm_pkg::NUM_LINKS],
	input  logic [SW-1:0]       link_to   [rnm_pkg::NUM_LINKS],
	input  logic [rnm_pkg::NUM_LINKS-1:0] link_en,
	output logic [7:0]          char_out,
	output logic [N-1:0]        row_out,
	output logic [N-1:0]        upd_out,
	output logic                hit
);
	import rnm_pkg::*;

	logic [7:0]   char_q;
	logic [N-1:0] row_q;
	logic [N-1:0] link_mask;

	always_comb begin
		link_mask = '0;
		for (int l = 0; l < NUM_LINKS; l++) begin
			if (link_en[l] && link_from[l] == SW'(P))
				link_mask[link_to[l]] = 1'b1;
		end
	end

	assign upd_out  = row_q | (row_q[k] ? bcast : '0);
	assign char_out = char_q;
	assign row_out  = row_q;
	assign hit      = (char_q == symbol) || (char_q == CH_DOT);

	always_ff @(posedge clk) begin
		if (ctrl.load_char && wr_idx == SW'(P))
			char_q <= ctrl.char_in;
		else if (ctrl.rotate)
			char_q <= char_next;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear_row)
			row_q <= {{(N-1){1'b0}}, 1'b1} << P;
		else if (ctrl.add_links)
			row_q <= row_q | link_mask;
		else if (ctrl.close_step)
			row_q <= row_next;
	end

endmodule

@@ rtl/core/rnm_checker.sv @@
// Port-level checks of the NFA line matcher, bound to the top level.
// Depends on rnm_pkg, assert_macros.svh, regex_nfa_line_matcher_core.
`include "assert_macros.svh"

module rnm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_action,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_kind,
	input logic       rsp_matched,
	input logic       rsp_pattern_error
);
	import rnm_pkg::*;

	`RNM_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`RNM_ASSERT_IMP(a_status_no_match, clk, arst_n, rsp_valid && rsp_kind == KIND_STATUS, !rsp_matched)
	`RNM_ASSERT_IMP(a_match_clean, clk, arst_n, rsp_valid && rsp_matched, !rsp_pattern_error)
	`RNM_ASSERT_NXT(a_build_busy, clk, arst_n, req_valid && req_ready && req_action == ACT_BUILD, !req_ready)

endmodule

bind regex_nfa_line_matcher_core rnm_checker u_rnm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_action        (req.action),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_kind          (rsp.kind),
	.rsp_matched       (rsp.matched),
	.rsp_pattern_error (rsp.pattern_error)
);
